FILE: src/sefr_pkg.sv
// Shared constants and controller/datapath handshake types for the frame receiver.
`timescale 1ns / 1ps

package sefr_pkg;

  localparam int BYTE_W      = 8;
  localparam int MAX_PAYLOAD = 64;
  localparam int ADDR_W      = $clog2(MAX_PAYLOAD);
  localparam int LEN_W       = $clog2(MAX_PAYLOAD + 1);
  localparam int CFG_IDX_W   = 1;

  localparam logic [CFG_IDX_W-1:0] REG_START_MARKER = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_END_MARKER   = 1'd1;

  localparam logic [BYTE_W-1:0] START_MARKER_RST = 8'h02;
  localparam logic [BYTE_W-1:0] END_MARKER_RST   = 8'h03;

  typedef logic [BYTE_W-1:0] byte_t;
  typedef logic [LEN_W-1:0]  len_t;
  typedef logic [ADDR_W-1:0] addr_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic clear_frame;
    logic load_len;
    logic store_byte;
    logic start_burst;
    logic emit_beat;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic is_start;
    logic is_end;
    logic len_ok;
    logic xor_ok;
    logic data_done;
    logic burst_last;
    logic out_free;
  } sts_t;

endpackage

FILE: src/sefr_if.sv
// Valid/ready channel interfaces for received bytes and payload results.
`timescale 1ns / 1ps

interface sefr_in_if;
  import sefr_pkg::*;
  logic  valid;
  logic  ready;
  byte_t rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

interface sefr_out_if;
  import sefr_pkg::*;
  logic  valid;
  logic  ready;
  byte_t payload_byte;
  len_t  frame_length;
  logic  last;

  modport source (output valid, output payload_byte, output frame_length, output last,
                  input ready);
  modport sink (input valid, input payload_byte, input frame_length, input last,
                output ready);
endinterface

FILE: src/sefr_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module sefr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: src/sefr_ctrl.sv
// Frame state machine: hunts for frames, walks length/data/checksum/end, runs the burst.
`timescale 1ns / 1ps

module sefr_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  sefr_pkg::sts_t sts,
  output sefr_pkg::cmd_t cmd
);
  import sefr_pkg::*;

  localparam logic [2:0] ST_HUNT = 3'd0;
  localparam logic [2:0] ST_LEN  = 3'd1;
  localparam logic [2:0] ST_DATA = 3'd2;
  localparam logic [2:0] ST_CHK  = 3'd3;
  localparam logic [2:0] ST_END  = 3'd4;
  localparam logic [2:0] ST_EMIT = 3'd5;

  logic [2:0] state;
  logic [2:0] state_next;
  logic       in_fire;

  assign in_ready = (state != ST_EMIT);
  assign in_fire  = in_valid && in_ready;

  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      ST_HUNT: begin
        if (in_fire && sts.is_start) begin
          cmd.clear_frame = 1'b1;
          state_next      = ST_LEN;
        end
      end
      ST_LEN: begin
        if (in_fire) begin
          if (sts.len_ok) begin
            cmd.load_len = 1'b1;
            state_next   = ST_DATA;
          end else begin
            state_next = ST_HUNT;
          end
        end
      end
      ST_DATA: begin
        if (in_fire) begin
          cmd.store_byte = 1'b1;
          if (sts.data_done) begin
            state_next = ST_CHK;
          end
        end
      end
      ST_CHK: begin
        if (in_fire) begin
          state_next = sts.xor_ok ? ST_END : ST_HUNT;
        end
      end
      ST_END: begin
        if (in_fire) begin
          if (sts.is_end) begin
            cmd.start_burst = 1'b1;
            state_next      = ST_EMIT;
          end else begin
            state_next = ST_HUNT;
          end
        end
      end
      ST_EMIT: begin
        if (sts.out_free) begin
          cmd.emit_beat = 1'b1;
          if (sts.burst_last) begin
            state_next = ST_HUNT;
          end
        end
      end
      default: begin
        state_next = ST_HUNT;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_HUNT;
    end else begin
      state <= state_next;
    end
  end

endmodule

FILE: src/sefr_dp.sv
// Datapath: marker registers, payload store, running XOR, counters and output register.
`timescale 1ns / 1ps

module sefr_dp (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_we,
  input  logic [sefr_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  sefr_pkg::byte_t                   cfg_wdata,
  input  sefr_pkg::byte_t                   rx_byte,
  input  logic                              out_ready,
  output logic                              out_valid,
  output sefr_pkg::byte_t                   out_byte,
  output sefr_pkg::len_t                    out_len,
  output logic                              out_last,
  input  sefr_pkg::cmd_t                    cmd,
  output sefr_pkg::sts_t                    sts
);
  import sefr_pkg::*;

  byte_t start_marker;
  byte_t end_marker;
  byte_t running_xor;
  len_t  write_index;
  len_t  bytes_left;
  addr_t rd_idx;
  byte_t rd_data;
  logic  rd_en;
  addr_t rd_addr;

  assign sts.is_start   = (rx_byte == start_marker);
  assign sts.is_end     = (rx_byte == end_marker);
  assign sts.len_ok     = (rx_byte != '0) && (rx_byte <= BYTE_W'(MAX_PAYLOAD));
  assign sts.xor_ok     = (rx_byte == running_xor);
  assign sts.data_done  = (bytes_left == LEN_W'(1));
  assign sts.burst_last = ((LEN_W'(rd_idx) + LEN_W'(1)) == write_index);
  assign sts.out_free   = !out_valid || out_ready;

  // The first read is issued with the end byte; each beat then prefetches the next entry.
  assign rd_en   = cmd.start_burst || (cmd.emit_beat && !sts.burst_last);
  assign rd_addr = cmd.start_burst ? '0 : rd_idx + ADDR_W'(1);

  sefr_ram #(
    .WIDTH (BYTE_W),
    .DEPTH (MAX_PAYLOAD)
  ) u_store (
    .clk   (clk),
    .we    (cmd.store_byte),
    .waddr (write_index[ADDR_W-1:0]),
    .wdata (rx_byte),
    .re    (rd_en),
    .raddr (rd_addr),
    .rdata (rd_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      start_marker <= START_MARKER_RST;
      end_marker   <= END_MARKER_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_START_MARKER: start_marker <= cfg_wdata;
        REG_END_MARKER:   end_marker   <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      running_xor <= '0;
      write_index <= '0;
      bytes_left  <= '0;
    end else begin
      priority if (cmd.clear_frame) begin
        running_xor <= '0;
        write_index <= '0;
        bytes_left  <= '0;
      end else if (cmd.load_len) begin
        bytes_left <= rx_byte[LEN_W-1:0];
      end else if (cmd.store_byte) begin
        running_xor <= running_xor ^ rx_byte;
        write_index <= write_index + LEN_W'(1);
        bytes_left  <= bytes_left - LEN_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start_burst) begin
      rd_idx <= '0;
    end else if (cmd.emit_beat && !sts.burst_last) begin
      rd_idx <= rd_idx + ADDR_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit_beat) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit_beat) begin
      out_byte <= rd_data;
      out_len  <= write_index;
      out_last <= sts.burst_last;
    end
  end

endmodule

FILE: src/stx_etx_xor_frame_receiver.sv
// Top level of the framed packet receiver with XOR checksum.
//
//   port       dir   what moves per beat
//   rx         in    one received byte (rx_byte)
//   payload    out   one payload byte, frame_length, last
//   cfg_*      in    marker register write, no handshake
//
// A received byte is accepted in every frame state; rx.ready drops only while a frame is
// read out of the payload store. The burst gives one beat per cycle while the consumer
// takes them, set by the store's single registered read port: new input is held off for
// the whole burst of a frame, including any stall time on payload.
// Reset is synchronous and returns the block to hunting with the default markers.
`timescale 1ns / 1ps

module stx_etx_xor_frame_receiver (
  input  logic                           clk,
  input  logic                           rst,
  sefr_in_if.sink                        rx,
  sefr_out_if.source                     payload,
  input  logic                           cfg_we,
  input  logic [sefr_pkg::CFG_IDX_W-1:0] cfg_index,
  input  sefr_pkg::byte_t                cfg_wdata
);
  import sefr_pkg::*;

  cmd_t cmd;
  sts_t sts;

  sefr_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (rx.valid),
    .in_ready (rx.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  sefr_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .rx_byte   (rx.rx_byte),
    .out_ready (payload.ready),
    .out_valid (payload.valid),
    .out_byte  (payload.payload_byte),
    .out_len   (payload.frame_length),
    .out_last  (payload.last),
    .cmd       (cmd),
    .sts       (sts)
  );

  // Every beat of a burst reports the same frame length.
  a_len_steady: assert property (@(posedge clk) disable iff (rst)
    (payload.valid && payload.ready && !payload.last)
      |=> (payload.frame_length == $past(payload.frame_length)))
    else $error("frame_length changed inside a burst");

  a_len_range: assert property (@(posedge clk) disable iff (rst)
    payload.valid |-> (payload.frame_length != '0 &&
                       payload.frame_length <= LEN_W'(MAX_PAYLOAD)))
    else $error("frame_length out of range");

  // A new frame needs several input bytes, so nothing follows the last beat at once.
  a_gap_after_last: assert property (@(posedge clk) disable iff (rst)
    (payload.valid && payload.ready && payload.last) |=> !payload.valid)
    else $error("beat emitted right after the last beat of a frame");

  // Input is held off for the whole burst, including the cycle after the end byte.
  a_hold_input: assert property (@(posedge clk) disable iff (rst)
    (cmd.start_burst) |=> !rx.ready)
    else $error("input accepted while a burst starts");

endmodule

FILE: tb/stx_etx_xor_frame_receiver_tb.sv
// Self-checking testbench for the framed packet receiver with XOR checksum.
`timescale 1ns / 1ps

module stx_etx_xor_frame_receiver_tb;
  import sefr_pkg::*;

  localparam int WATCHDOG_LIMIT = 4000;
  localparam int STALL_LEN      = 400;
  localparam int DRAIN_CYCLES   = 8;

  typedef enum logic [2:0] {
    ST_HUNT, ST_LEN, ST_DATA, ST_CHK, ST_END
  } frame_state_e;

  typedef struct {
    byte_t data;
    len_t  len;
    logic  last;
  } payload_beat_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic                 cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = REG_START_MARKER;
  byte_t                cfg_wdata = '0;

  sefr_in_if  rx_ch ();
  sefr_out_if pl_ch ();

  stx_etx_xor_frame_receiver dut (
    .clk       (clk),
    .rst       (rst),
    .rx        (rx_ch),
    .payload   (pl_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always #1 clk = ~clk;

  // Shadow copy of the receiver's framing state.
  frame_state_e fr_state;
  byte_t        fr_store [MAX_PAYLOAD];
  byte_t        fr_xor;
  int unsigned  fr_wr_idx;
  int unsigned  fr_left;
  byte_t        start_mk;
  byte_t        end_mk;

  payload_beat_t beats_due [$];
  payload_beat_t head_beat;

  int send_idle_pct = 0;
  int sink_idle_pct = 0;
  logic stall_request = 1'b0;
  logic stall_done = 1'b0;
  int stall_cycles = 0;

  int errors = 0;
  int bytes_sent = 0;
  int frames_delivered = 0;
  int beats_checked = 0;
  int idle_cycles = 0;

  // Advance the shadow state by one received byte and queue any payload beats it releases.
  function automatic void predict_rx_byte(byte_t b);
    payload_beat_t beat;
    case (fr_state)
      ST_LEN: begin
        if (b == 0 || int'(b) > MAX_PAYLOAD) begin
          fr_state = ST_HUNT;
          fr_wr_idx = 0;
          fr_left = 0;
        end else begin
          fr_left = b;
          fr_state = ST_DATA;
        end
      end
      ST_DATA: begin
        if (fr_wr_idx < MAX_PAYLOAD) begin
          fr_store[fr_wr_idx] = b;
          fr_wr_idx++;
        end
        fr_xor ^= b;
        if (fr_left > 0) fr_left--;
        if (fr_left == 0) fr_state = ST_CHK;
      end
      ST_CHK: begin
        if (b == fr_xor) begin
          fr_state = ST_END;
        end else begin
          fr_state = ST_HUNT;
          fr_wr_idx = 0;
        end
      end
      ST_END: begin
        if (b == end_mk) begin
          for (int i = 0; i < fr_wr_idx; i++) begin
            beat.data = fr_store[i];
            beat.len  = len_t'(fr_wr_idx);
            beat.last = (i + 1 == fr_wr_idx);
            beats_due.push_back(beat);
          end
          frames_delivered++;
        end
        fr_state = ST_HUNT;
      end
      default: begin
        fr_state = ST_HUNT;
        if (b == start_mk) begin
          fr_wr_idx = 0;
          fr_left = 0;
          fr_xor = '0;
          fr_state = ST_LEN;
        end
      end
    endcase
  endfunction

  task automatic send_byte(input byte_t b);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      @(negedge clk);
      rx_ch.valid <= 1'b0;
    end
    @(negedge clk);
    rx_ch.valid   <= 1'b1;
    rx_ch.rx_byte <= b;
    @(posedge clk);
    while (!rx_ch.ready) @(posedge clk);
    predict_rx_byte(b);
    bytes_sent++;
  endtask

  task automatic send_bytes(input byte_t seq [$]);
    foreach (seq[i]) send_byte(seq[i]);
  endtask

  // A frame with the current markers; the checksum or end byte can be spoiled on purpose.
  task automatic send_frame(input int n, input bit bad_sum, input bit bad_end);
    byte_t seq [$];
    byte_t sum;
    byte_t d;
    sum = '0;
    seq.push_back(start_mk);
    seq.push_back(byte_t'(n));
    repeat (n) begin
      d = byte_t'($urandom);
      sum ^= d;
      seq.push_back(d);
    end
    seq.push_back(bad_sum ? sum ^ byte_t'($urandom_range(1, 255)) : sum);
    seq.push_back(bad_end ? end_mk ^ byte_t'($urandom_range(1, 255)) : end_mk);
    send_bytes(seq);
  endtask

  // Let every queued beat drain and the block settle before a register write.
  task automatic wait_idle();
    @(negedge clk);
    rx_ch.valid <= 1'b0;
    while (beats_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_marker(input logic [CFG_IDX_W-1:0] idx, input byte_t value);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    @(negedge clk);
    cfg_we <= 1'b0;
    if (idx == REG_START_MARKER) start_mk = value;
    else if (idx == REG_END_MARKER) end_mk = value;
  endtask

  task automatic test_directed_cases();
    send_bytes('{8'h00, 8'hFF});
    send_bytes('{START_MARKER_RST, 8'h01, 8'hFF, 8'hFF, END_MARKER_RST});
    send_bytes('{START_MARKER_RST, 8'h00});
    send_bytes('{START_MARKER_RST, 8'(MAX_PAYLOAD + 1)});
    // The failing checksum byte equals the start marker and must not open a frame.
    send_bytes('{START_MARKER_RST, 8'h01, 8'h05, START_MARKER_RST, 8'h01});
    // Likewise for a wrong end byte.
    send_bytes('{START_MARKER_RST, 8'h01, 8'h00, 8'h00, START_MARKER_RST});
    send_bytes('{START_MARKER_RST, 8'h02, START_MARKER_RST, END_MARKER_RST, 8'h01,
                 END_MARKER_RST});
  endtask

  task automatic test_random_frames(input int item_target, input bit with_max_frame);
    int first;
    int roll;
    first = bytes_sent;
    if (with_max_frame) send_frame(MAX_PAYLOAD, 1'b0, 1'b0);
    while (bytes_sent - first < item_target) begin
      roll = $urandom_range(0, 99);
      if (roll < 68) begin
        send_frame($urandom_range(1, 8), 1'b0, 1'b0);
      end else if (roll < 74) begin
        send_bytes('{start_mk, $urandom_range(0, 1) ? 8'h00
                     : byte_t'($urandom_range(MAX_PAYLOAD + 1, 255))});
      end else if (roll < 82) begin
        send_frame($urandom_range(1, 8), 1'b1, 1'b0);
      end else if (roll < 90) begin
        send_frame($urandom_range(1, 8), 1'b0, 1'b1);
      end else begin
        repeat ($urandom_range(1, 3)) send_byte(byte_t'($urandom));
      end
    end
  endtask

  // The sink holds off long enough that a burst stalls and the input backs up behind it.
  task automatic test_input_backpressure();
    stall_request = 1'b1;
    repeat (2) send_frame(6, 1'b0, 1'b0);
    wait (stall_done);
    stall_request = 1'b0;
  endtask

  initial begin
    rx_ch.valid   = 1'b0;
    rx_ch.rx_byte = '0;
    fr_state  = ST_HUNT;
    fr_xor    = '0;
    fr_wr_idx = 0;
    fr_left   = 0;
    start_mk  = START_MARKER_RST;
    end_mk    = END_MARKER_RST;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    send_idle_pct = 18;
    sink_idle_pct = 63;
    test_directed_cases();
    wait_idle();
    write_marker(REG_START_MARKER, 8'h00);
    write_marker(REG_END_MARKER, 8'hFF);
    test_random_frames(12, 1'b0);

    send_idle_pct = 63;
    sink_idle_pct = 18;
    wait_idle();
    write_marker(REG_START_MARKER, 8'hFF);
    write_marker(REG_END_MARKER, 8'h00);
    test_random_frames(12, 1'b0);

    send_idle_pct = 0;
    sink_idle_pct = 0;
    wait_idle();
    write_marker(REG_START_MARKER, byte_t'($urandom));
    write_marker(REG_END_MARKER, byte_t'($urandom));
    test_random_frames(10, 1'b1);

    wait_idle();
    write_marker(REG_START_MARKER, START_MARKER_RST);
    write_marker(REG_END_MARKER, END_MARKER_RST);
    test_input_backpressure();

    wait_idle();
    repeat (20) @(posedge clk);
    $display("Sent %0d bytes under four marker settings and three idle patterns,",
             bytes_sent);
    $display("with %0d frames delivered and %0d payload beats checked (%0d mismatches).",
             frames_delivered, beats_checked, errors);
    if (errors == 0) $display("RESULT: OK");
    else $display("RESULT: ERROR");
    $finish;
  end

  initial begin
    pl_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (rst) begin
        pl_ch.ready <= 1'b0;
      end else if (stall_request && !stall_done) begin
        pl_ch.ready <= 1'b0;
        stall_cycles++;
        if (stall_cycles == STALL_LEN) stall_done = 1'b1;
      end else begin
        pl_ch.ready <= ($urandom_range(0, 99) >= sink_idle_pct);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && pl_ch.valid && pl_ch.ready) begin
      if (beats_due.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("unexpected payload beat: data %h len %0d last %b",
                   pl_ch.payload_byte, pl_ch.frame_length, pl_ch.last);
      end else begin
        head_beat = beats_due.pop_front();
        if (pl_ch.payload_byte !== head_beat.data || pl_ch.frame_length !== head_beat.len ||
            pl_ch.last !== head_beat.last) begin
          errors++;
          if (errors <= 10)
            $display("beat %0d mismatch: expected data %h len %0d last %b, got %h %0d %b",
                     beats_checked, head_beat.data, head_beat.len, head_beat.last,
                     pl_ch.payload_byte, pl_ch.frame_length, pl_ch.last);
        end
        beats_checked++;
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (rx_ch.valid && rx_ch.ready) || (pl_ch.valid && pl_ch.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("Watchdog: no beat moved for %0d cycles, %0d beats still due.",
                 WATCHDOG_LIMIT, beats_due.size());
        $display("RESULT: ERROR");
        $finish;
      end
    end
  end

endmodule
